// ===== rtl/sqd_pkg.sv =====
`default_nettype none

package sqd_pkg;

    // table depth and address width
    localparam int DIM_MAX = 1024;
    localparam int ADDR_W  = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // configuration register indexes
    localparam logic REG_METRIC    = 1'b0;
    localparam logic REG_DIMENSION = 1'b1;

    // command codes
    localparam logic [2:0] CMD_LOAD_STEP  = 3'd0;
    localparam logic [2:0] CMD_LOAD_QUERY = 3'd1;
    localparam logic [2:0] CMD_ENCODE     = 3'd2;
    localparam logic [2:0] CMD_DECODE     = 3'd3;
    localparam logic [2:0] CMD_DISTANCE   = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_ENCODE   = 2'd0;
    localparam logic [1:0] KIND_DECODE   = 2'd1;
    localparam logic [1:0] KIND_DISTANCE = 2'd2;

    // metric codes
    localparam logic [1:0] METRIC_COSINE = 2'd0;
    localparam logic [1:0] METRIC_DOT    = 2'd1;
    localparam logic [1:0] METRIC_EUCLID = 2'd2;

    // operation handed from front to back
    typedef enum logic [1:0] {
        OP_LOAD_ERR,
        OP_ENCODE,
        OP_DECODE,
        OP_DISTANCE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        ok;
        logic        last;
        logic [7:0]  code;
        logic [31:0] sample;
        logic [31:0] offset;
        logic [31:0] step;
        logic [31:0] query;
    } work_t;

endpackage

`default_nettype wire

// ===== rtl/scalar_quantizer_distance_engine_core.sv =====
`default_nettype none

// 8-bit scalar quantizer with asymmetric distance, signed Q16.16 data. The front
// takes one transaction per cycle while its queue has room: loads of offset/step
// and query elements finish there and produce no result unless the index is out
// of range. Other transactions read the tables and wait in a four-entry queue for
// the back end, which handles one at a time: decode, encode (bit-serial quotient,
// one level bit a cycle), a distance element (four 22x22 partial products on one
// multiplier), with a final step on the last element, plus a square root for
// euclidean (one root bit a cycle). The back end starts its next transaction only
// after the finished result on the output has been popped, so a stalled receiver
// fills the queue and then stalls the input. Tables hold no reset value; read only
// entries that were loaded.
module scalar_quantizer_distance_engine_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [2:0]           cmd,
    input  wire logic [15:0]          dim_index,
    input  wire logic signed [31:0]   sample,
    input  wire logic [31:0]          step_size,
    input  wire logic [7:0]           code,
    input  wire logic                 last,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [1:0]                kind,
    output logic [7:0]                enc_code,
    output logic signed [31:0]        sample_out,
    output logic signed [63:0]        distance,
    output logic                      status,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_addr,
    input  wire logic [10:0]          cfg_wdata
);

    logic [1:0]                      metric_reg;
    logic [10:0]                     dimension_reg;
    logic                            q_push;
    sqd_pkg::work_t                  q_wdata;
    logic                            q_pop;
    sqd_pkg::work_t                  q_rdata;
    logic                            q_empty;
    logic [sqd_pkg::FIFO_AW:0]       q_level;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg    <= sqd_pkg::METRIC_EUCLID;
            dimension_reg <= 11'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                sqd_pkg::REG_METRIC:    metric_reg    <= cfg_wdata[1:0];
                sqd_pkg::REG_DIMENSION: dimension_reg <= cfg_wdata;
                default:                metric_reg    <= metric_reg;
            endcase
        end
    end

    // classify and fetch
    sqd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .dim_index  (dim_index),
        .sample     (sample),
        .step_size  (step_size),
        .code       (code),
        .last       (last),
        .dimension  (dimension_reg),
        .fifo_level (q_level),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    // decoupling queue
    sqd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .empty   (q_empty),
        .level   (q_level)
    );

    // arithmetic
    sqd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_data     (q_rdata),
        .metric     (metric_reg),
        .pop        (pop),
        .empty      (empty),
        .kind       (kind),
        .enc_code   (enc_code),
        .sample_out (sample_out),
        .distance   (distance),
        .status     (status)
    );

endmodule

`default_nettype wire

// ===== rtl/sqd_fifo.sv =====
`default_nettype none

module sqd_fifo (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire sqd_pkg::work_t              wr_data,
    input  wire logic                        rd_en,
    output sqd_pkg::work_t                   rd_data,
    output logic                             empty,
    output logic [sqd_pkg::FIFO_AW:0]        level
);

    sqd_pkg::work_t                 entry_reg [sqd_pkg::FIFO_DEPTH];
    logic [sqd_pkg::FIFO_AW-1:0]    wr_ptr_reg;
    logic [sqd_pkg::FIFO_AW-1:0]    rd_ptr_reg;
    logic [sqd_pkg::FIFO_AW:0]      count_reg;

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign rd_data = entry_reg[rd_ptr_reg];
    assign empty   = (count_reg == '0);
    assign level   = count_reg;

endmodule

`default_nettype wire

// ===== rtl/sqd_front.sv =====
`default_nettype none

module sqd_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [2:0]                  cmd,
    input  wire logic [15:0]                 dim_index,
    input  wire logic signed [31:0]          sample,
    input  wire logic [31:0]                 step_size,
    input  wire logic [7:0]                  code,
    input  wire logic                        last,
    input  wire logic [10:0]                 dimension,
    input  wire logic [sqd_pkg::FIFO_AW:0]   fifo_level,
    output logic                             q_push,
    output sqd_pkg::work_t                   q_data
);

    logic [63:0]                  ofs_step_mem [sqd_pkg::DIM_MAX];
    logic [31:0]                  query_mem    [sqd_pkg::DIM_MAX];
    logic [63:0]                  ofs_step_rd_reg;
    logic [31:0]                  query_rd_reg;

    logic                         s1_valid_reg;
    sqd_pkg::op_t                 s1_op_reg;
    logic                         s1_ok_reg;
    logic                         s1_last_reg;
    logic [7:0]                   s1_code_reg;
    logic [31:0]                  s1_sample_reg;

    logic                         accept;
    logic                         in_range;
    logic [sqd_pkg::ADDR_W-1:0]   addr;
    logic                         fwd;
    sqd_pkg::op_t                 op_next;
    logic [sqd_pkg::FIFO_AW+1:0]  pending;

    // credit check: every item in flight has a queue slot
    assign pending = {1'b0, fifo_level} + {{(sqd_pkg::FIFO_AW+1){1'b0}}, s1_valid_reg};
    assign full    = (pending >= (sqd_pkg::FIFO_AW+2)'(sqd_pkg::FIFO_DEPTH));
    assign accept  = push && !full;

    // index check against configured and physical depth
    assign in_range = (dim_index < {5'b0, dimension})
                   && (dim_index < 16'(sqd_pkg::DIM_MAX));
    assign addr = dim_index[sqd_pkg::ADDR_W-1:0];

    // classify the item
    always_comb
    begin
        fwd     = 1'b0;
        op_next = sqd_pkg::OP_LOAD_ERR;
        unique case (cmd)
            sqd_pkg::CMD_LOAD_STEP, sqd_pkg::CMD_LOAD_QUERY:
            begin
                fwd     = !in_range;
                op_next = sqd_pkg::OP_LOAD_ERR;
            end
            sqd_pkg::CMD_ENCODE:
            begin
                fwd     = 1'b1;
                op_next = sqd_pkg::OP_ENCODE;
            end
            sqd_pkg::CMD_DECODE:
            begin
                fwd     = 1'b1;
                op_next = sqd_pkg::OP_DECODE;
            end
            sqd_pkg::CMD_DISTANCE:
            begin
                fwd     = 1'b1;
                op_next = sqd_pkg::OP_DISTANCE;
            end
            default:
            begin
                fwd     = 1'b0;
                op_next = sqd_pkg::OP_LOAD_ERR;
            end
        endcase
    end

    // parameter tables, registered read
    always_ff @(posedge clk)
    begin
        if (accept && in_range && (cmd == sqd_pkg::CMD_LOAD_STEP))
        begin
            ofs_step_mem[addr] <= {sample, step_size};
        end
        if (accept && in_range && (cmd == sqd_pkg::CMD_LOAD_QUERY))
        begin
            query_mem[addr] <= sample;
        end
        ofs_step_rd_reg <= ofs_step_mem[addr];
        query_rd_reg    <= query_mem[addr];
    end

    // stage waiting for table data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && fwd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg     <= op_next;
            s1_ok_reg     <= in_range;
            s1_last_reg   <= last;
            s1_code_reg   <= code;
            s1_sample_reg <= sample;
        end
    end

    // queue write
    assign q_push        = s1_valid_reg;
    assign q_data.op     = s1_op_reg;
    assign q_data.ok     = s1_ok_reg;
    assign q_data.last   = s1_last_reg;
    assign q_data.code   = s1_code_reg;
    assign q_data.sample = s1_sample_reg;
    assign q_data.offset = ofs_step_rd_reg[63:32];
    assign q_data.step   = ofs_step_rd_reg[31:0];
    assign q_data.query  = query_rd_reg;

endmodule

`default_nettype wire

// ===== rtl/sqd_back.sv =====
`default_nettype none

module sqd_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_empty,
    output logic                      q_pop,
    input  wire sqd_pkg::work_t       q_data,
    input  wire logic [1:0]           metric,
    input  wire logic                 pop,
    output logic                      empty,
    output logic [1:0]                kind,
    output logic [7:0]                enc_code,
    output logic signed [31:0]        sample_out,
    output logic signed [63:0]        distance,
    output logic                      status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_VALUE,
        S_EXEC,
        S_DIV,
        S_MUL,
        S_ROUND,
        S_ADD,
        S_FIN,
        S_SQRT
    } state_t;

    localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ONE_Q = 64'h0000_0000_0001_0000;

    state_t              state_reg;
    sqd_pkg::work_t      w_reg;
    logic [41:0]         value_reg;
    logic [63:0]         acc_reg;
    logic [42:0]         ma_reg;
    logic [42:0]         mb_reg;
    logic                neg_reg;
    logic [85:0]         prod_reg;
    logic [63:0]         contrib_reg;
    logic [5:0]          cnt_reg;
    logic [41:0]         rem_reg;
    logic [41:0]         dsh_reg;
    logic [7:0]          quo_reg;
    logic [79:0]         rad_reg;
    logic [39:0]         root_reg;
    logic [43:0]         srem_reg;

    logic                out_valid_reg;
    logic [1:0]          kind_reg;
    logic [7:0]          enc_code_reg;
    logic [31:0]         sample_out_reg;
    logic [63:0]         distance_reg;
    logic                status_reg;

    logic [39:0]         code_x_step;
    logic [41:0]         value_calc;
    logic [32:0]         diff;
    logic [31:0]         step1;
    logic [41:0]         num;
    logic [42:0]         eu_diff;
    logic [42:0]         eu_mag;
    logic [31:0]         q_mag;
    logic [41:0]         v_mag;
    logic [31:0]         dec_sat;
    logic [21:0]         a_part;
    logic [21:0]         b_part;
    logic [43:0]         pp;
    logic [85:0]         pp_shift;
    logic [85:0]         rounded;
    logic [63:0]         m64;
    logic [43:0]         rem_t;
    logic [43:0]         trial;
    logic                fits32;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            sat_add = s[64] ? 64'h8000_0000_0000_0000 : MAX64;
        end
        else
        begin
            sat_add = s[63:0];
        end
    endfunction

    // value = offset + code * step
    assign code_x_step = {32'b0, w_reg.code} * {8'b0, w_reg.step};
    assign value_calc  = {{10{w_reg.offset[31]}}, w_reg.offset} + {2'b00, code_x_step};

    // decode saturation to 32 bits
    assign fits32  = (value_reg[41:31] == {11{value_reg[31]}});
    assign dec_sat = fits32 ? value_reg[31:0]
                   : (value_reg[41] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    // encode numerator (2*diff + step) over 2*step
    assign diff  = {w_reg.sample[31], w_reg.sample} - {w_reg.offset[31], w_reg.offset};
    assign step1 = (w_reg.step == 32'd0) ? 32'd1 : w_reg.step;
    assign num   = {9'b0, diff[31:0], 1'b0} + {10'b0, step1};

    // multiplier operands
    assign eu_diff = {{11{w_reg.query[31]}}, w_reg.query} - {value_reg[41], value_reg};
    assign eu_mag  = eu_diff[42] ? (43'd0 - eu_diff) : eu_diff;
    assign q_mag   = w_reg.query[31] ? (32'd0 - w_reg.query) : w_reg.query;
    assign v_mag   = value_reg[41] ? (42'd0 - value_reg) : value_reg;

    // one 22x22 partial product per cycle
    assign a_part   = cnt_reg[1] ? {1'b0, ma_reg[42:22]} : ma_reg[21:0];
    assign b_part   = cnt_reg[0] ? {1'b0, mb_reg[42:22]} : mb_reg[21:0];
    assign pp       = {22'b0, a_part} * {22'b0, b_part};
    assign pp_shift = ({42'b0, pp}) << (7'(cnt_reg[1]) * 7'd22 + 7'(cnt_reg[0]) * 7'd22);

    // round half away from zero, saturate magnitude
    assign rounded = prod_reg + 86'h8000;
    assign m64     = (rounded[85:79] != 7'd0) ? MAX64 : {1'b0, rounded[78:16]};

    // square root digit step
    assign rem_t = {srem_reg[41:0], rad_reg[79:78]};
    assign trial = {2'b00, root_reg, 2'b01};

    assign q_pop = (state_reg == S_IDLE) && !q_empty && !out_valid_reg;

    // sequencer, accumulator and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        w_reg     <= q_data;
                        state_reg <= S_VALUE;
                    end
                end
                S_VALUE:
                begin
                    value_reg <= value_calc;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    kind_reg       <= sqd_pkg::KIND_ENCODE;
                    enc_code_reg   <= '0;
                    sample_out_reg <= '0;
                    distance_reg   <= '0;
                    status_reg     <= !w_reg.ok;
                    unique case (w_reg.op)
                        sqd_pkg::OP_LOAD_ERR:
                        begin
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        sqd_pkg::OP_DECODE:
                        begin
                            kind_reg       <= sqd_pkg::KIND_DECODE;
                            sample_out_reg <= w_reg.ok ? dec_sat : 32'd0;
                            out_valid_reg  <= 1'b1;
                            state_reg      <= S_IDLE;
                        end
                        sqd_pkg::OP_ENCODE:
                        begin
                            if (!w_reg.ok || diff[32] || (diff == 33'd0))
                            begin
                                out_valid_reg <= 1'b1;
                                state_reg     <= S_IDLE;
                            end
                            else
                            begin
                                rem_reg   <= num;
                                dsh_reg   <= {1'b0, step1, 9'b0};
                                quo_reg   <= '0;
                                cnt_reg   <= '0;
                                state_reg <= S_DIV;
                            end
                        end
                        sqd_pkg::OP_DISTANCE:
                        begin
                            kind_reg <= sqd_pkg::KIND_DISTANCE;
                            if (w_reg.ok)
                            begin
                                if (metric == sqd_pkg::METRIC_EUCLID)
                                begin
                                    ma_reg  <= eu_mag;
                                    mb_reg  <= eu_mag;
                                    neg_reg <= 1'b0;
                                end
                                else
                                begin
                                    ma_reg  <= {11'b0, q_mag};
                                    mb_reg  <= {1'b0, v_mag};
                                    neg_reg <= w_reg.query[31] ^ value_reg[41];
                                end
                                prod_reg  <= '0;
                                cnt_reg   <= '0;
                                state_reg <= S_MUL;
                            end
                            else if (w_reg.last)
                            begin
                                state_reg <= S_FIN;
                            end
                            else
                            begin
                                out_valid_reg <= 1'b1;
                                state_reg     <= S_IDLE;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_DIV:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        // level of 256 or more clamps
                        if (rem_reg >= dsh_reg)
                        begin
                            enc_code_reg  <= 8'hFF;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        dsh_reg <= dsh_reg >> 1;
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                    else
                    begin
                        if (rem_reg >= dsh_reg)
                        begin
                            rem_reg <= rem_reg - dsh_reg;
                            quo_reg <= {quo_reg[6:0], 1'b1};
                        end
                        else
                        begin
                            quo_reg <= {quo_reg[6:0], 1'b0};
                        end
                        dsh_reg <= dsh_reg >> 1;
                        cnt_reg <= cnt_reg + 6'd1;
                        if (cnt_reg == 6'd8)
                        begin
                            enc_code_reg  <= {quo_reg[6:0], (rem_reg >= dsh_reg)};
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                end
                S_MUL:
                begin
                    prod_reg <= prod_reg + pp_shift;
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd3)
                    begin
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    // dot and cosine add the negated product
                    if ((metric != sqd_pkg::METRIC_EUCLID) && !neg_reg)
                    begin
                        contrib_reg <= 64'd0 - m64;
                    end
                    else
                    begin
                        contrib_reg <= m64;
                    end
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    acc_reg   <= sat_add(acc_reg, contrib_reg);
                    state_reg <= w_reg.last ? S_FIN : S_IDLE;
                end
                S_FIN:
                begin
                    acc_reg <= '0;
                    if (metric == sqd_pkg::METRIC_EUCLID)
                    begin
                        if (acc_reg[63] || (acc_reg == 64'd0))
                        begin
                            distance_reg  <= '0;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            rad_reg   <= {1'b0, acc_reg[62:0], 16'b0};
                            root_reg  <= '0;
                            srem_reg  <= '0;
                            cnt_reg   <= '0;
                            state_reg <= S_SQRT;
                        end
                    end
                    else
                    begin
                        if (metric == sqd_pkg::METRIC_COSINE)
                        begin
                            distance_reg <= sat_add(ONE_Q, acc_reg);
                        end
                        else
                        begin
                            distance_reg <= acc_reg;
                        end
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_SQRT:
                begin
                    rad_reg <= {rad_reg[77:0], 2'b00};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (rem_t >= trial)
                    begin
                        srem_reg <= rem_t - trial;
                        root_reg <= {root_reg[38:0], 1'b1};
                    end
                    else
                    begin
                        srem_reg <= rem_t;
                        root_reg <= {root_reg[38:0], 1'b0};
                    end
                    if (cnt_reg == 6'd39)
                    begin
                        distance_reg  <= {24'b0, root_reg[38:0], (rem_t >= trial)};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign empty      = !out_valid_reg;
    assign kind       = kind_reg;
    assign enc_code   = enc_code_reg;
    assign sample_out = sample_out_reg;
    assign distance   = distance_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire
